### sv/dwbm_pkg.sv
// Package for the depth window background mask block.
// Field widths, register indexes, request codes and the stage structs.
// No dependencies.
package dwbm_pkg;

	localparam int DIST_W     = 13;               // near/far register width
	localparam int DEPTH_W    = 16;
	localparam int IDX_W      = 18;
	localparam int PIX_W      = 8;
	localparam int TOL_W      = 8;
	localparam int QBITS      = 8;                // quotient bits, 255 = 2**QBITS - 1
	localparam int NUM_W      = 25;               // signed 255 * (far - depth)
	localparam int DEN_W      = DIST_W + 1;       // signed far - near
	localparam int REM_W      = DIST_W + QBITS;   // remainder while quotient < 256
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIST_W;

	localparam logic [CFG_IDX_W-1:0] REG_NEAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL  = 2'd2;

	localparam logic REQ_PROCESS = 1'b0;
	localparam logic REQ_CAPTURE = 1'b1;

	localparam logic [DIST_W-1:0] NEAR_RST = 13'd1000;
	localparam logic [DIST_W-1:0] FAR_RST  = 13'd2200;
	localparam logic [TOL_W-1:0]  TOL_RST  = 8'd20;
	localparam logic [PIX_W-1:0]  PIX_MAX  = 8'd255;

	// one divider stage
	typedef struct packed {
		logic              req;
		logic [IDX_W-1:0]  idx;
		logic              zero;
		logic              eq;
		logic              neg;
		logic              big;
		logic [DIST_W-1:0] d;
		logic [REM_W-1:0]  rem;
		logic [QBITS-1:0]  q;
	} div_st_t;

	// mapper -> background stage
	typedef struct packed {
		logic             valid;
		logic             req;
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] mapped;
	} map_res_t;

	// background stage -> output buffer
	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] mapped;
		logic [PIX_W-1:0] masked;
	} out_item_t;

endpackage

### sv/dwbm_map.sv
// Depth to 8-bit brightness mapper: scale, sign fix, range check and an
// 8-stage restoring divider, one quotient bit per stage. Uses dwbm_pkg.
module dwbm_map import dwbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               accept,
	input  logic               req_type,
	input  logic [IDX_W-1:0]   pixel_index,
	input  logic [DEPTH_W-1:0] depth_mm,
	input  logic [DIST_W-1:0]  near_mm,
	input  logic [DIST_W-1:0]  far_mm,
	output map_res_t           res
);

	logic signed [NUM_W-1:0] diff;
	logic signed [NUM_W-1:0] num;
	logic signed [DEN_W-1:0] den;

	logic                    v_s1;
	logic                    req_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    zero_s1;
	logic                    eq_s1;
	logic signed [NUM_W-1:0] num_s1;
	logic signed [DEN_W-1:0] den_s1;

	logic                    den_neg;
	logic signed [NUM_W-1:0] n_abs;
	logic signed [DEN_W-1:0] d_abs;

	logic                    v_s2;
	logic                    req_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic                    zero_s2;
	logic                    eq_s2;
	logic signed [NUM_W-1:0] n_s2;
	logic [DIST_W-1:0]       d_s2;

	logic                    neg;
	logic                    big;

	// div_s[0] is stage 3, div_s[QBITS] is the last divider stage
	div_st_t                 div_s [QBITS+1];
	logic [QBITS:0]          div_v_s;

	assign diff = $signed(NUM_W'({1'b0, far_mm})) - $signed(NUM_W'({1'b0, depth_mm}));
	assign num  = (diff <<< QBITS) - diff;
	assign den  = $signed(DEN_W'({1'b0, far_mm})) - $signed(DEN_W'({1'b0, near_mm}));

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1  <= req_type;
			idx_s1  <= pixel_index;
			zero_s1 <= (depth_mm == '0);
			eq_s1   <= (far_mm == near_mm);
			num_s1  <= num;
			den_s1  <= den;
		end
	end

	// floor(n/d) with d < 0 equals floor(-n / -d)
	assign den_neg = den_s1[DEN_W-1];
	assign n_abs   = den_neg ? -num_s1 : num_s1;
	assign d_abs   = den_neg ? -den_s1 : den_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2  <= req_s1;
			idx_s2  <= idx_s1;
			zero_s2 <= zero_s1;
			eq_s2   <= eq_s1;
			n_s2    <= n_abs;
			d_s2    <= d_abs[DIST_W-1:0];
		end
	end

	assign neg = n_s2[NUM_W-1];
	assign big = !neg &&
		($unsigned(n_s2) >= {{(NUM_W-REM_W){1'b0}}, d_s2, {QBITS{1'b0}}});

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].req  <= req_s2;
			div_s[0].idx  <= idx_s2;
			div_s[0].zero <= zero_s2;
			div_s[0].eq   <= eq_s2;
			div_s[0].neg  <= neg;
			div_s[0].big  <= big;
			div_s[0].d    <= d_s2;
			div_s[0].rem  <= n_s2[REM_W-1:0];
			div_s[0].q    <= '0;
		end
	end

	for (genvar i = 0; i < QBITS; i++) begin : g_div
		localparam int K = QBITS - 1 - i;
		logic [REM_W-1:0] dsh;
		logic             ge;
		div_st_t          nxt;

		assign dsh = {{QBITS{1'b0}}, div_s[i].d} << K;
		assign ge  = (div_s[i].rem >= dsh);

		always_comb begin
			nxt     = div_s[i];
			nxt.rem = ge ? (div_s[i].rem - dsh) : div_s[i].rem;
			nxt.q   = div_s[i].q | (ge ? (QBITS'(1) << K) : '0);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[i+1] <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			div_v_s <= '0;
		end else if (adv) begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			div_v_s <= {div_v_s[QBITS-1:0], v_s2};
		end
	end

	always_comb begin
		res.valid = div_v_s[QBITS];
		res.req   = div_s[QBITS].req;
		res.idx   = div_s[QBITS].idx;
		if (div_s[QBITS].zero)
			res.mapped = '0;
		else if (div_s[QBITS].eq)
			res.mapped = PIX_MAX;
		else if (div_s[QBITS].neg)
			res.mapped = '0;
		else if (div_s[QBITS].big)
			res.mapped = PIX_MAX;
		else
			res.mapped = div_s[QBITS].q;
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[QBITS] && !div_s[QBITS].eq && !div_s[QBITS].neg && !div_s[QBITS].big
		|-> div_s[QBITS].rem < {{QBITS{1'b0}}, div_s[QBITS].d})
		else $error("divider remainder not below divisor");

endmodule

### sv/dwbm_bg.sv
// Background store: frame-sized memory with a clearing pass after reset,
// capture writes, process reads and the tolerance compare. Uses dwbm_pkg.
module dwbm_bg import dwbm_pkg::*; #(
	parameter int FRAME_WIDTH  = 512,
	parameter int FRAME_HEIGHT = 424
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  map_res_t         res,
	input  logic [TOL_W-1:0] tol_thresh,
	output logic             clr_busy,
	output out_item_t        item
);

	localparam int unsigned PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	logic [PIX_W-1:0]  mem [PIXELS];

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic [31:0]       idx_ext;
	logic              in_frame;
	logic [ADDR_W-1:0] addr;
	logic              wr_en;
	logic              rd_en;

	logic              v_s12;
	logic              req_s12;
	logic              in_frame_s12;
	logic [PIX_W-1:0]  mapped_s12;
	logic [PIX_W-1:0]  bg_s12;

	logic [PIX_W-1:0]  bg;
	logic [PIX_W:0]    excess;
	logic              keep;

	assign idx_ext  = 32'(res.idx);
	assign in_frame = (idx_ext < PIXELS);
	assign addr     = idx_ext[ADDR_W-1:0];
	// one access per beat: a capture writes, a process reads; a process that
	// follows a capture to the same pixel reads after the write and sees it
	assign wr_en   = adv && res.valid && (res.req == REQ_CAPTURE) && in_frame;
	assign rd_en   = adv && res.valid && (res.req == REQ_PROCESS) && in_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(PIXELS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_cnt_q] <= '0;
		else if (wr_en)
			mem[addr] <= res.mapped;
		if (rd_en)
			bg_s12 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s12 <= 1'b0;
		else if (adv)
			v_s12 <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s12      <= res.req;
			in_frame_s12 <= in_frame;
			mapped_s12   <= res.mapped;
		end
	end

	assign bg     = in_frame_s12 ? bg_s12 : '0;
	assign excess = {1'b0, mapped_s12} - {1'b0, bg};
	assign keep   = (req_s12 == REQ_PROCESS) && !excess[PIX_W] &&
		(excess[PIX_W-1:0] > tol_thresh);

	assign clr_busy    = clr_busy_q;
	assign item.valid  = v_s12 && adv;
	assign item.mapped = mapped_s12;
	assign item.masked = keep ? mapped_s12 : '0;

	a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !res.valid && !v_s12)
		else $error("pixel in flight during background clear");

endmodule

### sv/dwbm_out.sv
// Output register plus one skid entry, so the pipeline stall is a register.
// Uses dwbm_pkg.
module dwbm_out import dwbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  out_item_t        item,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [PIX_W-1:0] mapped_depth,
	output logic [PIX_W-1:0] masked_depth,
	output logic             skid_full
);

	logic             out_valid_q;
	logic [PIX_W-1:0] out_mapped_q;
	logic [PIX_W-1:0] out_masked_q;
	logic             skid_full_q;
	logic [PIX_W-1:0] skid_mapped_q;
	logic [PIX_W-1:0] skid_masked_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_free) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= item.valid;
			end
		end else if (item.valid) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_full_q) begin
				out_mapped_q <= skid_mapped_q;
				out_masked_q <= skid_masked_q;
			end else if (item.valid) begin
				out_mapped_q <= item.mapped;
				out_masked_q <= item.masked;
			end
		end else if (item.valid) begin
			skid_mapped_q <= item.mapped;
			skid_masked_q <= item.masked;
		end
	end

	assign out_valid    = out_valid_q;
	assign mapped_depth = out_mapped_q;
	assign masked_depth = out_masked_q;
	assign skid_full    = skid_full_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid holds a beat while output register is empty");

	a_no_push_into_full: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid |-> !skid_full_q)
		else $error("beat delivered while skid entry is full");

endmodule

### sv/depth_window_background_mask.sv
// Depth window background mask, top level.
// Input channel (in_valid/in_stall): one beat carries req_type, pixel_index
// and depth_mm. Output channel (out_valid/out_stall): one beat per input beat,
// in order, with mapped_depth and masked_depth.
// Configuration: cfg_we with cfg_index (0 near_mm, 1 far_mm, 2 tolerance)
// and cfg_data; other indexes are dropped. Write only while idle.
// It takes one beat per cycle while in_stall is low. An accepted beat passes
// 13 registers, the first loaded at the accepting edge: 3 for scaling, sign
// fix and range check, 8 divider stages that each resolve one quotient bit,
// one for the background memory port, one output register.
// The memory port is single: a capture writes it, a process reads it.
// After reset the background memory is cleared one entry per cycle over the
// whole frame; in_stall is high for that whole pass. Config registers return
// to 1000, 2200 and 20.
// When out_stall holds a beat, one more beat goes into a skid entry and the
// pipeline then freezes; in_stall is high while the skid entry is full.
module depth_window_background_mask import dwbm_pkg::*; #(
	parameter int FRAME_WIDTH  = 512,
	parameter int FRAME_HEIGHT = 424
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [IDX_W-1:0]      pixel_index,
	input  logic [DEPTH_W-1:0]    depth_mm,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      mapped_depth,
	output logic [PIX_W-1:0]      masked_depth
);

	logic [DIST_W-1:0] near_q;
	logic [DIST_W-1:0] far_q;
	logic [TOL_W-1:0]  tol_q;

	logic              adv;
	logic              accept;
	logic              clr_busy;
	logic              skid_full;
	map_res_t          map_res;
	out_item_t         item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RST;
			far_q  <= FAR_RST;
			tol_q  <= TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEAR: near_q <= cfg_data;
				REG_FAR:  far_q  <= cfg_data;
				REG_TOL:  tol_q  <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !skid_full;
	assign in_stall = clr_busy || skid_full;
	assign accept   = in_valid && !in_stall;

	dwbm_map u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.accept      (accept),
		.req_type    (req_type),
		.pixel_index (pixel_index),
		.depth_mm    (depth_mm),
		.near_mm     (near_q),
		.far_mm      (far_q),
		.res         (map_res)
	);

	dwbm_bg #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_bg (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.res          (map_res),
		.tol_thresh   (tol_q),
		.clr_busy     (clr_busy),
		.item         (item)
	);

	dwbm_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.mapped_depth (mapped_depth),
		.masked_depth (masked_depth),
		.skid_full    (skid_full)
	);

endmodule

### verif/depth_window_background_mask_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for depth_window_background_mask: queued pixel beats, random idling.
// Predicts mapped/masked depth with a background mirror; depends on dwbm_pkg.
module depth_window_background_mask_tb;
	import dwbm_pkg::*;

	localparam int FRAME_WIDTH  = 512;
	localparam int FRAME_HEIGHT = 424;
	localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int QUIET_LIMIT  = 1000000;  // covers the background clear after reset
	localparam int DRAIN_CYCLES = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic              req;
		logic [IDX_W-1:0]  idx;
		logic [DEPTH_W-1:0] depth;
	} pix_beat_t;

	typedef struct {
		logic [PIX_W-1:0] mapped;
		logic [PIX_W-1:0] masked;
	} pix_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = REQ_PROCESS;
	logic [IDX_W-1:0]      pixel_index = '0;
	logic [DEPTH_W-1:0]    depth_mm = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIX_W-1:0]      mapped_depth;
	logic [PIX_W-1:0]      masked_depth;

	depth_window_background_mask #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.pixel_index (pixel_index),
		.depth_mm    (depth_mm),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mapped_depth(mapped_depth),
		.masked_depth(masked_depth)
	);

	// predictor state
	logic [DIST_W-1:0] near_cfg = NEAR_RST;
	logic [DIST_W-1:0] far_cfg  = FAR_RST;
	logic [TOL_W-1:0]  tol_cfg  = TOL_RST;
	bit   [PIX_W-1:0]  bg_mirror [FRAME_PIXELS];

	pix_beat_t   pending_pixels[$];
	pix_result_t expected_pixels[$];

	int  mismatches = 0;
	int  in_idle_pct = 20;
	int  out_stall_pct = 20;
	int  in_gap = 0;
	int  out_gap = 0;
	int  quiet_cycles = 0;
	bit  in_took = 1'b0;
	bit  out_took = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic pix_result_t window_and_mask(input pix_beat_t b);
		pix_result_t      r;
		longint           den, num, q, rem;
		logic [PIX_W-1:0] bg;
		if (b.depth == '0) begin
			r.mapped = '0;
		end else if (far_cfg == near_cfg) begin
			r.mapped = PIX_MAX;
		end else begin
			den = longint'(far_cfg) - longint'(near_cfg);
			num = 255 * (longint'(far_cfg) - longint'(b.depth));
			q   = num / den;
			rem = num % den;
			// round toward minus infinity
			if (rem != 0 && ((rem < 0) != (den < 0)))
				q = q - 1;
			if (q < 0)
				q = 0;
			if (q > 255)
				q = 255;
			r.mapped = q[PIX_W-1:0];
		end
		r.masked = '0;
		if (b.req == REQ_CAPTURE) begin
			if (b.idx < FRAME_PIXELS)
				bg_mirror[b.idx] = r.mapped;
		end else begin
			bg = (b.idx < FRAME_PIXELS) ? bg_mirror[b.idx] : '0;
			if (int'(r.mapped) - int'(bg) > int'(tol_cfg))
				r.masked = r.mapped;
		end
		return r;
	endfunction

	// monitor: register mirror, output check, prediction on input beats
	always @(posedge clk) begin
		pix_result_t want;
		pix_beat_t   seen;
		in_took  = 1'b0;
		out_took = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NEAR: near_cfg = cfg_data[DIST_W-1:0];
					REG_FAR:  far_cfg  = cfg_data[DIST_W-1:0];
					REG_TOL:  tol_cfg  = cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				out_took = 1'b1;
				if (expected_pixels.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: output beat with nothing expected: mapped %0d masked %0d",
							$realtime, mapped_depth, masked_depth);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (mapped_depth !== want.mapped || masked_depth !== want.masked) begin
						if (mismatches < 10)
							$display("%0t: mapped exp %0d got %0d, masked exp %0d got %0d",
								$realtime, want.mapped, mapped_depth, want.masked,
								masked_depth);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				in_took    = 1'b1;
				seen.req   = req_type;
				seen.idx   = pixel_index;
				seen.depth = depth_mm;
				expected_pixels.push_back(window_and_mask(seen));
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		pix_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// stalled beat holds
		end else if (in_gap > 0) begin
			in_gap--;
			in_valid <= 1'b0;
		end else if (pending_pixels.size() > 0 && $urandom_range(99) < in_idle_pct) begin
			in_gap = $urandom_range(4, 0);
			in_valid <= 1'b0;
		end else if (pending_pixels.size() > 0) begin
			nxt = pending_pixels.pop_front();
			in_valid    <= 1'b1;
			req_type    <= nxt.req;
			pixel_index <= nxt.idx;
			depth_mm    <= nxt.depth;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < out_stall_pct) begin
			out_gap = $urandom_range(4, 0);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (in_took || out_took)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_pixel(input logic req, input logic [IDX_W-1:0] idx,
			input logic [DEPTH_W-1:0] depth);
		pix_beat_t b;
		b.req   = req;
		b.idx   = idx;
		b.depth = depth;
		pending_pixels.push_back(b);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_pixels();
		while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_window(input logic [CFG_DATA_W-1:0] near_v,
			input logic [CFG_DATA_W-1:0] far_v, input logic [CFG_DATA_W-1:0] tol_v);
		write_reg(REG_NEAR, near_v);
		write_reg(REG_FAR, far_v);
		write_reg(REG_TOL, tol_v);
		@(negedge clk);
	endtask

	// mostly hits a small set of hot pixels so captures and processes meet
	task automatic random_pixels(input int count);
		logic [IDX_W-1:0]   hot [8];
		logic [IDX_W-1:0]   idx;
		logic [DEPTH_W-1:0] depth;
		logic               req;
		int                 lo, hi, roll;
		lo = (near_cfg < far_cfg) ? int'(near_cfg) : int'(far_cfg);
		hi = (near_cfg < far_cfg) ? int'(far_cfg) : int'(near_cfg);
		hot[0] = IDX_W'(FRAME_PIXELS - 1);
		hot[1] = IDX_W'(FRAME_PIXELS + $urandom_range(100, 0));
		for (int k = 2; k < 8; k++)
			hot[3'(k)] = IDX_W'($urandom_range(FRAME_PIXELS - 1, 0));
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			idx = (roll < 80) ? hot[3'($urandom_range(7, 0))] :
				IDX_W'($urandom_range(2**IDX_W - 1, 0));
			req = ($urandom_range(99) < 30) ? REQ_CAPTURE : REQ_PROCESS;
			roll = $urandom_range(99);
			if (roll < 5)
				depth = '0;
			else if (roll < 25)
				depth = DEPTH_W'($urandom_range(2**DEPTH_W - 1, 0));
			else
				depth = DEPTH_W'($urandom_range(hi + 64, (lo > 64) ? lo - 64 : 1));
			push_pixel(req, idx, depth);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window 1000..2200, tolerance 20
		push_pixel(REQ_PROCESS, 18'd0, 16'd0);
		push_pixel(REQ_CAPTURE, 18'd0, 16'd1000);
		push_pixel(REQ_PROCESS, 18'd0, 16'd1000);
		push_pixel(REQ_CAPTURE, 18'd5, 16'd2200);
		push_pixel(REQ_PROCESS, 18'd5, 16'd1000);
		push_pixel(REQ_PROCESS, 18'd5, 16'd2100);     // 21, just over tolerance
		push_pixel(REQ_PROCESS, 18'd5, 16'd2104);     // 20, right at tolerance
		push_pixel(REQ_PROCESS, 18'd5, 16'hFFFF);
		push_pixel(REQ_PROCESS, 18'd5, 16'd1);
		push_pixel(REQ_PROCESS, 18'd7, 16'd999);
		push_pixel(REQ_CAPTURE, IDX_W'(FRAME_PIXELS - 1), 16'd1600);
		push_pixel(REQ_PROCESS, IDX_W'(FRAME_PIXELS - 1), 16'd1500);
		push_pixel(REQ_CAPTURE, IDX_W'(FRAME_PIXELS), 16'd1000);   // out of frame: no write
		push_pixel(REQ_PROCESS, IDX_W'(FRAME_PIXELS), 16'd1500);
		push_pixel(REQ_PROCESS, 18'h3FFFF, 16'd1200);
		push_pixel(REQ_CAPTURE, 18'h3FFFF, 16'd2500);
		push_pixel(REQ_CAPTURE, 18'h1FFFF, 16'h8000);
		push_pixel(REQ_PROCESS, 18'h20000, 16'hFFFF);
		push_pixel(REQ_PROCESS, 18'h1FFFF, 16'h7FFF);
		drain_pixels();

		set_window(13'd100, 13'd8000, 13'd0);
		random_pixels(300);
		drain_pixels();

		// near beyond far
		in_idle_pct   = 40;
		out_stall_pct = 40;
		set_window(13'd8000, 13'd100, 13'd255);
		random_pixels(250);
		drain_pixels();

		// near equals far
		in_idle_pct   = 0;
		out_stall_pct = 0;
		set_window(13'd4000, 13'd4000, 13'd5);
		random_pixels(200);
		drain_pixels();

		// out-of-range values, tolerance takes the low byte, unused index dropped
		in_idle_pct   = 15;
		out_stall_pct = 30;
		set_window(13'h1FFF, 13'h0000, 13'h1E7F);
		write_reg(REG_UNUSED, 13'h0ABC);
		random_pixels(250);
		drain_pixels();

		set_window(13'd0, 13'h1FFF, 13'd10);
		random_pixels(250);
		drain_pixels();

		in_idle_pct   = 25;
		out_stall_pct = 10;
		set_window(13'd1500, 13'd1600, 13'd10);
		random_pixels(250);
		drain_pixels();

		// final stretch without idling
		in_idle_pct   = 0;
		out_stall_pct = 0;
		set_window(13'd200, 13'd7000, 13'd40);
		random_pixels(300);
		while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
